// ----- sv/rgbhsv_pkg.sv -----
`timescale 1ns / 1ps
package rgbhsv_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } pix_out_t;

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_t;

  // Classified pixel handed from the front end to the divider pipeline.
  typedef struct packed {
    logic       grey;
    sector_t    sector;
    logic       neg;
    logic [7:0] diff;
    logic [7:0] spread;
    logic [7:0] top;
  } cls_t;

  localparam int QDEPTH = 2;
  localparam int QW = $clog2(QDEPTH);
  // Both divisions give quotients below 256: run 8 restoring steps.
  localparam int DSTEPS = 8;

endpackage

// ----- sv/rgbhsv_front.sv -----
`timescale 1ns / 1ps
module rgbhsv_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rgbhsv_pkg::pix_in_t in_data,
  output logic                cls_valid,
  input  logic                cls_stall,
  output rgbhsv_pkg::cls_t    cls_data
);
  import rgbhsv_pkg::*;

  logic  [7:0] top, bot;
  cls_t        cls_nxt;
  cls_t        cls_r;
  logic        vld_r;
  logic        adv;

  always_comb begin
    top = in_data.red;
    if (in_data.green > top) top = in_data.green;
    if (in_data.blue > top) top = in_data.blue;
    bot = in_data.red;
    if (in_data.green < bot) bot = in_data.green;
    if (in_data.blue < bot) bot = in_data.blue;
    cls_nxt.top    = top;
    cls_nxt.spread = top - bot;
    cls_nxt.grey   = (top == 8'd0) || (top == bot);
    if (top == in_data.red) begin
      cls_nxt.sector = SECT_RED;
      cls_nxt.neg    = in_data.green < in_data.blue;
      cls_nxt.diff   = cls_nxt.neg ? in_data.blue - in_data.green
                                   : in_data.green - in_data.blue;
    end else if (top == in_data.green) begin
      cls_nxt.sector = SECT_GREEN;
      cls_nxt.neg    = in_data.blue < in_data.red;
      cls_nxt.diff   = cls_nxt.neg ? in_data.red - in_data.blue
                                   : in_data.blue - in_data.red;
    end else begin
      cls_nxt.sector = SECT_BLUE;
      cls_nxt.neg    = in_data.red < in_data.green;
      cls_nxt.diff   = cls_nxt.neg ? in_data.green - in_data.red
                                   : in_data.red - in_data.green;
    end
  end

  assign in_stall  = vld_r && cls_stall;
  assign adv       = !in_stall;
  assign cls_valid = vld_r;
  assign cls_data  = cls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      cls_r <= cls_nxt;
    end
  end

endmodule

// ----- sv/rgbhsv_queue.sv -----
`timescale 1ns / 1ps
module rgbhsv_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  rgbhsv_pkg::cls_t wr_data,
  output logic             rd_valid,
  input  logic             rd_stall,
  output rgbhsv_pkg::cls_t rd_data
);
  import rgbhsv_pkg::*;

  cls_t          mem_r [QDEPTH];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0]   cnt_r;
  logic          push, pop;

  assign wr_stall = (cnt_r == (QW+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ----- sv/rgbhsv_back.sv -----
`timescale 1ns / 1ps
module rgbhsv_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cls_valid,
  output logic                 cls_stall,
  input  rgbhsv_pkg::cls_t     cls_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rgbhsv_pkg::pix_out_t out_data
);
  import rgbhsv_pkg::*;

  // Stage 0 scales, stages 1..DSTEPS run one quotient bit each, last stage
  // wraps the hue. Both dividends are below 256*divisor.
  localparam int NS = DSTEPS + 2;

  logic        vld_r  [NS];
  cls_t        c_r    [DSTEPS+1];
  logic [15:0] hrem_r [DSTEPS+1];
  logic [15:0] srem_r [DSTEPS+1];
  logic [7:0]  hq_r   [DSTEPS+1];
  logic [7:0]  sq_r   [DSTEPS+1];
  pix_out_t    res_r;
  logic        adv;
  logic [8:0]  base;
  logic [9:0]  hsum;

  assign adv       = !(vld_r[NS-1] && out_stall);
  assign cls_stall = !adv;
  assign out_valid = vld_r[NS-1];
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= cls_valid;
      for (int i = 1; i < NS; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r[0]    <= cls_data;
      hrem_r[0] <= 16'(cls_data.diff) * 16'd60;
      srem_r[0] <= 16'(cls_data.spread) * 16'd255;
      hq_r[0]   <= '0;
      sq_r[0]   <= '0;
      for (int i = 1; i <= DSTEPS; i++) begin
        automatic int sh = DSTEPS - i;
        automatic logic [15:0] hd = 16'(c_r[i-1].spread) << sh;
        automatic logic [15:0] sd = 16'(c_r[i-1].top) << sh;
        c_r[i] <= c_r[i-1];
        if (c_r[i-1].spread != 8'd0 && hrem_r[i-1] >= hd) begin
          hrem_r[i] <= hrem_r[i-1] - hd;
          hq_r[i]   <= hq_r[i-1] | (8'd1 << sh);
        end else begin
          hrem_r[i] <= hrem_r[i-1];
          hq_r[i]   <= hq_r[i-1];
        end
        if (c_r[i-1].top != 8'd0 && srem_r[i-1] >= sd) begin
          srem_r[i] <= srem_r[i-1] - sd;
          sq_r[i]   <= sq_r[i-1] | (8'd1 << sh);
        end else begin
          srem_r[i] <= srem_r[i-1];
          sq_r[i]   <= sq_r[i-1];
        end
      end
      res_r.hue        <= c_r[NS-2].grey ? 9'd0 : hsum[8:0];
      res_r.saturation <= c_r[NS-2].grey ? 8'd0 : sq_r[NS-2];
      res_r.brightness <= c_r[NS-2].top;
    end
  end

  always_comb begin
    case (c_r[NS-2].sector)
      SECT_RED:   base = 9'd0;
      SECT_GREEN: base = 9'd120;
      SECT_BLUE:  base = 9'd240;
      default:    base = 9'd0;
    endcase
    // Quotient is at most 60; add the sector base, wrap negatives by 360.
    if (c_r[NS-2].neg) begin
      hsum = 10'(base) + 10'd360 - 10'(hq_r[NS-2]);
      if (hsum >= 10'd360) hsum = hsum - 10'd360;
    end else begin
      hsum = 10'(base) + 10'(hq_r[NS-2]);
    end
  end

  unused_vld_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hue < 9'd360)
    else $error("hue out of range");
  black_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.brightness == 8'd0 |->
      out_data.hue == 9'd0 && out_data.saturation == 8'd0)
    else $error("black pixel with nonzero hue or saturation");

endmodule

// ----- sv/rgb_to_hsv_integer.sv -----
`timescale 1ns / 1ps
// Path: a classify register, the queue, then the divider and hue-wrap stages.
// Throughput: one pixel per clock while no stall is asserted; two parallel 8-step
// restoring divider pipelines (hue and saturation) set the depth.
// Reset: synchronous active-low rst_n clears all valid flags and the queue;
// no other state.
module rgb_to_hsv_integer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rgbhsv_pkg::pix_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rgbhsv_pkg::pix_out_t out_data
);
  import rgbhsv_pkg::*;

  logic f_valid, f_stall, b_valid, b_stall;
  cls_t f_data, b_data;

  rgbhsv_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cls_valid(f_valid), .cls_stall(f_stall), .cls_data(f_data)
  );

  rgbhsv_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
    .rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_data)
  );

  rgbhsv_back u_back (
    .clk, .rst_n,
    .cls_valid(b_valid), .cls_stall(b_stall), .cls_data(b_data),
    .out_valid, .out_stall, .out_data
  );

endmodule
